// File: hw/rtl/mua_pkg.sv
// ----------------------------------------------------------------------------
// mua_pkg: shared constants for the minutes-until-alarm block
// Field widths, calendar constants and the month-length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package mua_pkg;

  // Request field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int RESULT_W = 20;

  // Calendar constants
  localparam int MINS_PER_HOUR = 60;
  localparam int MINS_PER_DAY  = 1440;
  localparam int LAST_MONTH    = 12;
  localparam logic [RESULT_W-1:0] OUT_MAX = '1;

  // Month counter runs one past the last month of the 4-bit field
  localparam int MON_CNT_W = MONTH_W + 1;

  // Days in a month; years with year mod 4 == 0 are leap years.
  // Codes outside January..December count as 30 days.
  function automatic logic [DAY_W-1:0] days_in_month(
    input logic [MON_CNT_W-1:0] m,
    input logic [1:0]           year_lo
  );
    logic [DAY_W-1:0] d;
    begin
      unique case (m)
        5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: d = 5'd31;
        5'd2:    d = (year_lo == 2'd0) ? 5'd29 : 5'd28;
        default: d = 5'd30;
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/minutes_until_alarm_top.sv
// Sequence: S_IDLE latches the request, S_LOAD forms the time-of-day difference
// and the first day count, S_SUM adds whole months (switching to next year's months
// when the count rolls over), S_SCALE scales days to minutes, S_FINAL loads the result.
// Flow: one request at a time; the next request is taken once the result is loaded
// into the output register, while the result may still wait there.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// minutes_until_alarm_top: minutes from the current date/time to an alarm
// Walks the months between now and the alarm with one day accumulator, then
// scales the day count to minutes and saturates to the 20-bit result.
// ----------------------------------------------------------------------------
`default_nettype none

module minutes_until_alarm_top
  import mua_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [YEAR_W-1:0]   now_year,
  input  wire logic [MONTH_W-1:0]  now_month,
  input  wire logic [DAY_W-1:0]    now_day,
  input  wire logic [HOUR_W-1:0]   now_hour,
  input  wire logic [MINUTE_W-1:0] now_minute,
  input  wire logic [MONTH_W-1:0]  target_month,
  input  wire logic [DAY_W-1:0]    target_day,
  input  wire logic [HOUR_W-1:0]   target_hour,
  input  wire logic [MINUTE_W-1:0] target_minute,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [RESULT_W-1:0]      minutes_until
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_SCALE,
    S_FINAL
  } state_t;

  localparam int DAYS_W  = 12;  // signed day count
  localparam int MINS_W  = 12;  // time of day in minutes
  localparam int DIFF_W  = MINS_W + 1;
  localparam int PROD_W  = 24;
  localparam int TOTAL_W = PROD_W + 1;

  state_t state;

  // Latched request
  logic [1:0]          yr_lo;
  logic [MONTH_W-1:0]  cm;
  logic [DAY_W-1:0]    cd;
  logic [HOUR_W-1:0]   ch;
  logic [MINUTE_W-1:0] cmin;
  logic [MONTH_W-1:0]  tm;
  logic [DAY_W-1:0]    td;
  logic [HOUR_W-1:0]   th;
  logic [MINUTE_W-1:0] tmin;

  // Working registers
  logic                    roll;   // alarm rolls into next year
  logic                    wrap;   // now walking next year's months
  logic [MON_CNT_W-1:0]    mon;
  logic signed [DAYS_W-1:0]  days;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;

  // Combinational helpers
  logic [MINS_W-1:0]         now_mins;
  logic [MINS_W-1:0]         tgt_mins;
  logic signed [DAYS_W-1:0]  head_days;
  logic signed [DAYS_W-1:0]  span_days;
  logic                      same_day_later;
  logic [1:0]                sum_year;
  logic                      sum_first_year;
  logic [MON_CNT_W-1:0]      sum_limit;
  logic signed [DAYS_W-1:0]  days_add;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [TOTAL_W-1:0] total;
  logic [RESULT_W-1:0]       result_next;

  assign in_ready = (state == S_IDLE);

  // Time of day in minutes and the day count before any whole months
  always_comb begin
    now_mins  = MINS_W'(ch) * MINS_W'(MINS_PER_HOUR) + MINS_W'(cmin);
    tgt_mins  = MINS_W'(th) * MINS_W'(MINS_PER_HOUR) + MINS_W'(tmin);
    head_days = $signed(DAYS_W'(days_in_month({1'b0, cm}, yr_lo)))
              - $signed(DAYS_W'(cd)) + $signed(DAYS_W'(td));
    span_days = $signed(DAYS_W'(td)) - $signed(DAYS_W'(cd));
    same_day_later = (th > ch) || ((th == ch) && (tmin > cmin));
  end

  // Shared day adder: one month length per cycle
  always_comb begin
    sum_first_year = roll && !wrap;
    sum_year  = wrap ? (yr_lo + 2'd1) : yr_lo;
    sum_limit = sum_first_year ? MON_CNT_W'(LAST_MONTH) : ({1'b0, tm} - MON_CNT_W'(1));
    days_add  = days + $signed(DAYS_W'(days_in_month(mon, sum_year)));
  end

  // Scale to minutes, add the time-of-day difference, saturate
  always_comb begin
    prod_next = $signed({{(PROD_W-DAYS_W){days[DAYS_W-1]}}, days})
              * $signed(PROD_W'(MINS_PER_DAY));
    total = $signed({prod[PROD_W-1], prod})
          + $signed({{(TOTAL_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    if (total[TOTAL_W-1]) begin
      result_next = '0;
    end else if (total[TOTAL_W-2:RESULT_W] != '0) begin
      result_next = OUT_MAX;
    end else begin
      result_next = total[RESULT_W-1:0];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads this cycle
      if (out_valid && out_ready && (state != S_FINAL)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            yr_lo <= now_year[1:0];
            cm    <= now_month;
            cd    <= now_day;
            ch    <= now_hour;
            cmin  <= now_minute;
            tm    <= target_month;
            td    <= target_day;
            th    <= target_hour;
            tmin  <= target_minute;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          diff <= $signed({1'b0, tgt_mins}) - $signed({1'b0, now_mins});
          wrap <= 1'b0;
          mon  <= {1'b0, cm} + MON_CNT_W'(1);
          priority if (cm < tm) begin
            roll  <= 1'b0;
            days  <= head_days;
            state <= S_SUM;
          end else if ((cm == tm) && (td > cd)) begin
            roll  <= 1'b0;
            days  <= span_days;
            state <= S_SCALE;
          end else if ((cm == tm) && (td == cd) && same_day_later) begin
            roll  <= 1'b0;
            days  <= '0;
            state <= S_SCALE;
          end else begin
            roll  <= 1'b1;
            days  <= head_days;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // Add months up to the limit, then switch to next year or finish
          if ((tm != '0 || sum_first_year) && mon <= sum_limit) begin
            days <= days_add;
            mon  <= mon + MON_CNT_W'(1);
          end else if (sum_first_year) begin
            wrap <= 1'b1;
            mon  <= MON_CNT_W'(1);
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod  <= prod_next;
          state <= S_FINAL;
        end
        S_FINAL: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            minutes_until <= result_next;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mua_checker.sv
// ----------------------------------------------------------------------------
// mua_checker: port-level checks for minutes_until_alarm_top
// Watches the request and result handshakes and the busy window.
// ----------------------------------------------------------------------------
`default_nettype none

module mua_checker
  import mua_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [RESULT_W-1:0] minutes_until
);

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(minutes_until)))
    else $error("stalled result changed");

  // An accepted request keeps the block busy through at least its load, scale and final steps
  a_busy_window: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready ##1 !in_ready))
    else $error("request taken too soon after previous one");

  // A new result only appears while a request is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no request in work");

endmodule

bind minutes_until_alarm_top mua_checker u_mua_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for minutes_until_alarm_top
// A queue of requests (directed corner cases, then random dates and times)
// feeds a clocked driver. Each accepted request is scored by a local
// calendar predictor, and a clocked monitor compares every result with the
// oldest predicted minute count. Both sides idle at random, with one long
// output hold-off and sender pauses that let the block run empty.
// ----------------------------------------------------------------------------

module testbench
  import mua_pkg::*;
;

  typedef struct {
    logic [YEAR_W-1:0]   now_year;
    logic [MONTH_W-1:0]  now_month;
    logic [DAY_W-1:0]    now_day;
    logic [HOUR_W-1:0]   now_hour;
    logic [MINUTE_W-1:0] now_minute;
    logic [MONTH_W-1:0]  target_month;
    logic [DAY_W-1:0]    target_day;
    logic [HOUR_W-1:0]   target_hour;
    logic [MINUTE_W-1:0] target_minute;
    bit                  drain_first;
  } alarm_req_t;

  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_LO     = 300;
  localparam int QUIET_HI     = 700;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 1000;
  localparam int TAIL_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [YEAR_W-1:0]   now_year      = '0;
  logic [MONTH_W-1:0]  now_month     = '0;
  logic [DAY_W-1:0]    now_day       = '0;
  logic [HOUR_W-1:0]   now_hour      = '0;
  logic [MINUTE_W-1:0] now_minute    = '0;
  logic [MONTH_W-1:0]  target_month  = '0;
  logic [DAY_W-1:0]    target_day    = '0;
  logic [HOUR_W-1:0]   target_hour   = '0;
  logic [MINUTE_W-1:0] target_minute = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [RESULT_W-1:0] minutes_until;

  alarm_req_t          request_q[$];
  logic [RESULT_W-1:0] expected_minutes_q[$];
  alarm_req_t          cur_req;
  logic [RESULT_W-1:0] want_minutes;
  int                  sent_count   = 0;
  int                  results_seen = 0;
  int                  mismatches   = 0;
  int                  hold_left    = 0;
  bit                  hold_done    = 1'b0;
  int                  gap_roll;

  minutes_until_alarm_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_year      (now_year),
    .now_month     (now_month),
    .now_day       (now_day),
    .now_hour      (now_hour),
    .now_minute    (now_minute),
    .target_month  (target_month),
    .target_day    (target_day),
    .target_hour   (target_hour),
    .target_minute (target_minute),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .minutes_until (minutes_until)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Month length; any code outside January..December counts as 30 days
  function automatic longint month_len(input int m, input int yr);
    longint d;
    case (m)
      1, 3, 5, 7, 8, 10, 12: d = 31;
      2:       d = (yr % 4 == 0) ? 29 : 28;
      default: d = 30;
    endcase
    return d;
  endfunction

  // Minutes until the next occurrence of the alarm, clamped to the result range
  function automatic logic [RESULT_W-1:0] predict_minutes(input alarm_req_t r);
    int     yr, cm, cd, ch, cmin, tm, td, th, tmin, i;
    longint now_mins, tgt_mins, days, total;
    yr   = int'(r.now_year);
    cm   = int'(r.now_month);
    cd   = int'(r.now_day);
    ch   = int'(r.now_hour);
    cmin = int'(r.now_minute);
    tm   = int'(r.target_month);
    td   = int'(r.target_day);
    th   = int'(r.target_hour);
    tmin = int'(r.target_minute);
    now_mins = ch * MINS_PER_HOUR + cmin;
    tgt_mins = th * MINS_PER_HOUR + tmin;
    if (cm < tm) begin
      // later month this year: rest of this month, months between, target day
      days = month_len(cm, yr) - cd + td;
      for (i = cm + 1; i < tm; i++) days += month_len(i, yr);
      total = days * MINS_PER_DAY - now_mins + tgt_mins;
    end else if (cm == tm && td > cd) begin
      total = longint'(td - cd) * MINS_PER_DAY - now_mins + tgt_mins;
    end else if (cm == tm && td == cd &&
                 (th > ch || (th == ch && tmin > cmin))) begin
      total = tgt_mins - now_mins;
    end else begin
      // roll over: rest of this year, then next year's months before the target
      days = month_len(cm, yr) - cd + td;
      for (i = cm + 1; i <= LAST_MONTH; i++) days += month_len(i, yr);
      for (i = 1; i < tm; i++) days += month_len(i, yr + 1);
      total = days * MINS_PER_DAY - now_mins + tgt_mins;
    end
    if (total < 0) total = 0;
    if (total > longint'(OUT_MAX)) total = longint'(OUT_MAX);
    return total[RESULT_W-1:0];
  endfunction

  task automatic add_request(input int y, nm, nd, nh, nmin, tm, td, th, tmin);
    alarm_req_t r;
    r.now_year      = YEAR_W'(y);
    r.now_month     = MONTH_W'(nm);
    r.now_day       = DAY_W'(nd);
    r.now_hour      = HOUR_W'(nh);
    r.now_minute    = MINUTE_W'(nmin);
    r.target_month  = MONTH_W'(tm);
    r.target_day    = DAY_W'(td);
    r.target_hour   = HOUR_W'(th);
    r.target_minute = MINUTE_W'(tmin);
    r.drain_first   = 1'b0;
    request_q.push_back(r);
  endtask

  // Mostly valid calendar values, steered so target and now often coincide
  function automatic alarm_req_t random_request();
    alarm_req_t r;
    int         mode;
    if ($urandom_range(0, 99) < 10) begin
      // raw noise over the full field widths
      r.now_year      = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
      r.now_month     = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
      r.now_day       = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
      r.now_hour      = HOUR_W'($urandom_range(0, (1 << HOUR_W) - 1));
      r.now_minute    = MINUTE_W'($urandom_range(0, (1 << MINUTE_W) - 1));
      r.target_month  = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
      r.target_day    = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
      r.target_hour   = HOUR_W'($urandom_range(0, (1 << HOUR_W) - 1));
      r.target_minute = MINUTE_W'($urandom_range(0, (1 << MINUTE_W) - 1));
    end else begin
      r.now_year      = YEAR_W'($urandom_range(2000, 2099));
      r.now_month     = MONTH_W'($urandom_range(1, 12));
      r.now_day       = DAY_W'($urandom_range(1, 31));
      r.now_hour      = HOUR_W'($urandom_range(0, 23));
      r.now_minute    = MINUTE_W'($urandom_range(0, 59));
      r.target_month  = MONTH_W'($urandom_range(1, 12));
      r.target_day    = DAY_W'($urandom_range(1, 31));
      r.target_hour   = HOUR_W'($urandom_range(0, 23));
      r.target_minute = MINUTE_W'($urandom_range(0, 59));
      mode = $urandom_range(0, 7);
      if (mode >= 1) r.target_month  = r.now_month;
      if (mode >= 3) r.target_day    = r.now_day;
      if (mode >= 5) r.target_hour   = r.now_hour;
      if (mode >= 7) r.target_minute = r.now_minute;
    end
    r.drain_first = 1'b0;
    return r;
  endfunction

  // Driver: score accepted requests, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_minutes_q.push_back(predict_minutes(cur_req));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        gap_roll = $urandom_range(0, 99);
        if (sent_count >= QUIET_LO && sent_count < QUIET_HI) gap_roll = 99;
        if (request_q.size() != 0 && gap_roll >= 8 &&
            !(request_q[0].drain_first && expected_minutes_q.size() != 0)) begin
          cur_req = request_q.pop_front();
          now_year      <= cur_req.now_year;
          now_month     <= cur_req.now_month;
          now_day       <= cur_req.now_day;
          now_hour      <= cur_req.now_hour;
          now_minute    <= cur_req.now_minute;
          target_month  <= cur_req.target_month;
          target_day    <= cur_req.target_day;
          target_hour   <= cur_req.target_hour;
          target_minute <= cur_req.target_minute;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, then pick ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_minutes_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, minutes_until);
          mismatches++;
        end else begin
          want_minutes = expected_minutes_q.pop_front();
          if (minutes_until !== want_minutes) begin
            $display("%0t: minutes_until expected %0d, actual %0d",
                     $time, want_minutes, minutes_until);
            mismatches++;
          end
        end
        results_seen++;
      end
      // hold off once for a long stretch so the block backs up
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin
    alarm_req_t r;
    int         k;
    // field extremes
    add_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(4095, 15, 31, 31, 63, 15, 31, 31, 63);
    add_request(2000, 1, 1, 0, 0, 12, 31, 23, 59);
    add_request(2099, 12, 31, 23, 59, 1, 1, 0, 0);
    // later month, across a leap and a common February
    add_request(2024, 1, 15, 10, 30, 3, 1, 8, 0);
    add_request(2023, 1, 15, 10, 30, 3, 1, 8, 0);
    // same month later day, same day later hour and later minute
    add_request(2023, 6, 10, 12, 0, 6, 20, 6, 0);
    add_request(2023, 6, 10, 12, 0, 6, 10, 18, 45);
    add_request(2023, 6, 10, 12, 30, 6, 10, 12, 31);
    // equal time and earlier time on the same day roll into next year
    add_request(2023, 6, 10, 12, 30, 6, 10, 12, 30);
    add_request(2023, 6, 10, 12, 30, 6, 10, 12, 29);
    add_request(2023, 6, 10, 12, 30, 6, 10, 11, 59);
    // earlier day this month, earlier month into a leap year
    add_request(2023, 6, 10, 12, 30, 6, 9, 12, 30);
    add_request(2023, 11, 5, 7, 15, 2, 10, 7, 15);
    // year end to next January, one minute apart
    add_request(2023, 12, 31, 23, 59, 1, 1, 0, 0);
    // month codes outside January..December
    add_request(2030, 13, 5, 1, 1, 15, 6, 2, 2);
    add_request(2030, 0, 5, 1, 1, 14, 6, 2, 2);
    add_request(2030, 5, 5, 1, 1, 0, 6, 2, 2);
    add_request(2030, 15, 0, 0, 0, 15, 0, 0, 0);
    // negative totals clamp to zero
    add_request(2022, 3, 31, 31, 63, 4, 0, 0, 0);
    add_request(2022, 3, 5, 31, 63, 3, 6, 0, 0);
    // out-of-range hours in the same-day comparison
    add_request(2022, 8, 8, 24, 0, 8, 8, 30, 0);
    add_request(2022, 8, 8, 30, 62, 8, 8, 30, 63);
    // random part, with pauses that let the block drain
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      r = random_request();
      r.drain_first = (k == 0 || k == DRAIN_AT);
      request_q.push_back(r);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_minutes_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("minutes_until_alarm_top: match");
    end else begin
      $display("minutes_until_alarm_top: mismatch");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("minutes_until_alarm_top: mismatch");
    $finish;
  end

endmodule
